[rtl/tspb_pkg.sv]
package tspb_pkg;

  // Transport-stream framing constants.
  localparam logic [7:0] SYNC_BYTE    = 8'h47;
  localparam logic [7:0] HDR_BYTE     = 8'd3;
  localparam logic [7:0] SEC_BYTE     = 8'd12;
  localparam logic [7:0] ENTRY_BASE   = 8'd13;
  localparam logic [11:0] SEC_FIXED   = 12'd9;
  localparam int unsigned HDR_STORE_DEPTH = 12;

  // Depth of the record queue between the parser and the formatter.
  localparam int unsigned REC_DEPTH = 4;
  localparam int unsigned REC_AW    = $clog2(REC_DEPTH);

  // Record tags written by the parser.
  localparam logic [1:0] TAG_HDR   = 2'd0;
  localparam logic [1:0] TAG_SEC   = 2'd1;
  localparam logic [1:0] TAG_ENTRY = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_HDR = 2'd0;
  localparam logic [1:0] KIND_SEC = 2'd1;
  localparam logic [1:0] KIND_NET = 2'd2;
  localparam logic [1:0] KIND_PMT = 2'd3;

  // One classified record: a tag and the raw bytes the formatter needs.
  typedef struct packed {
    logic [1:0]  tag;
    logic [63:0] payload;
  } rec_t;

  // One formatted result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [12:0] pid;
    logic [15:0] number;
    logic [7:0]  tbl_id;
    logic [11:0] sec_len;
    logic [4:0]  version;
    logic [2:0]  flags;
    logic [7:0]  sec_num;
    logic [7:0]  last_section;
    logic [1:0]  scrambling;
    logic [1:0]  adaptation;
    logic [3:0]  continuity;
  } res_t;

endpackage

[rtl/tspb_front.sv]
module tspb_front #(
  parameter int PACKET_BYTES = 188,
  parameter int MAX_ENTRIES  = 43
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic [7:0]    in_data_byte,
  output logic          rec_push,
  output tspb_pkg::rec_t rec
);
  import tspb_pkg::*;

  localparam logic [8:0] PKT_BYTES = 9'(PACKET_BYTES);
  localparam logic [5:0] MAX_N     = 6'(MAX_ENTRIES);

  logic                 in_packet_r, in_packet_nxt;
  logic [7:0]           byte_index_r, byte_index_nxt;
  logic [5:0]           entries_left_r, entries_left_nxt;
  logic [23:0]          entry_hold_r, entry_hold_nxt;
  logic [7:0]           hdr_r [HDR_STORE_DEPTH];
  logic                 hdr_we;
  logic [7:0]           idx_m1;
  logic [7:0]           ent_off;
  logic [11:0]          slen;
  logic [11:0]          slen_m9;
  logic [9:0]           n_raw;
  logic [5:0]           n_cap;
  logic [8:0]           idx_p1;

  // Section length and the capped entry count, from stored header bytes.
  assign slen    = {hdr_r[5][3:0], hdr_r[6]};
  assign slen_m9 = slen - SEC_FIXED;
  assign n_raw   = (slen >= SEC_FIXED) ? slen_m9[11:2] : 10'd0;
  assign n_cap   = (n_raw > {4'd0, MAX_N}) ? MAX_N : n_raw[5:0];

  assign idx_m1  = byte_index_r - 8'd1;
  assign ent_off = byte_index_r - ENTRY_BASE;
  assign idx_p1  = {1'b0, byte_index_r} + 9'd1;

  // Per-byte classification and packet tracking.
  always_comb begin
    in_packet_nxt    = in_packet_r;
    byte_index_nxt   = byte_index_r;
    entries_left_nxt = entries_left_r;
    entry_hold_nxt   = entry_hold_r;
    hdr_we           = 1'b0;
    rec_push         = 1'b0;
    rec              = '0;
    if (acc) begin
      if (!in_packet_r) begin
        if (in_data_byte == SYNC_BYTE) begin
          in_packet_nxt  = 1'b1;
          byte_index_nxt = 8'd1;
        end
      end else begin
        hdr_we = (byte_index_r >= 8'd1) && (byte_index_r <= SEC_BYTE);
        if (byte_index_r == HDR_BYTE) begin
          rec_push = 1'b1;
          rec.tag  = TAG_HDR;
          rec.payload = {40'd0, hdr_r[0], hdr_r[1], in_data_byte};
        end else if (byte_index_r == SEC_BYTE) begin
          rec_push         = 1'b1;
          rec.tag          = TAG_SEC;
          rec.payload      = {hdr_r[4], hdr_r[5], hdr_r[6], hdr_r[7], hdr_r[8],
                              hdr_r[9], hdr_r[10], in_data_byte};
          entries_left_nxt = n_cap;
        end else if (byte_index_r >= ENTRY_BASE) begin
          if (ent_off[1:0] != 2'd3) begin
            entry_hold_nxt = {entry_hold_r[15:0], in_data_byte};
          end else if (entries_left_r != 6'd0) begin
            rec_push         = 1'b1;
            rec.tag          = TAG_ENTRY;
            rec.payload      = {32'd0, entry_hold_r, in_data_byte};
            entries_left_nxt = entries_left_r - 6'd1;
          end
        end
        // Packet end: go back to hunting for sync.
        if (idx_p1 >= PKT_BYTES) begin
          in_packet_nxt    = 1'b0;
          byte_index_nxt   = 8'd0;
          entries_left_nxt = 6'd0;
        end else begin
          byte_index_nxt = idx_p1[7:0];
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_packet_r    <= 1'b0;
      byte_index_r   <= 8'd0;
      entries_left_r <= 6'd0;
    end else begin
      in_packet_r    <= in_packet_nxt;
      byte_index_r   <= byte_index_nxt;
      entries_left_r <= entries_left_nxt;
    end
  end

  // Header bytes and the partial program entry.
  always_ff @(posedge clk) begin
    entry_hold_r <= entry_hold_nxt;
    if (hdr_we) begin
      hdr_r[idx_m1[3:0]] <= in_data_byte;
    end
  end

`ifndef SYNTHESIS
  a_hunt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_packet_r |-> (byte_index_r == 8'd0 && entries_left_r == 6'd0))
    else $error("Hunting state carries a byte index or entry count.");

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    entries_left_r <= MAX_N)
    else $error("Entry count exceeds the cap.");

  a_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !in_packet_r && in_data_byte == SYNC_BYTE) |=>
      (in_packet_r && byte_index_r == 8'd1))
    else $error("Sync byte did not start a packet.");
`endif

endmodule

[rtl/tspb_fifo.sv]
module tspb_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  tspb_pkg::rec_t wr_data,
  output logic           fifo_full,
  input  logic           rd_en,
  output tspb_pkg::rec_t rd_data,
  output logic           fifo_valid
);
  import tspb_pkg::*;

  rec_t              mem_r [REC_DEPTH];
  logic [REC_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [REC_AW:0]   count_r;
  logic              do_wr, do_rd;

  assign fifo_full  = (count_r == (REC_AW+1)'(REC_DEPTH));
  assign fifo_valid = (count_r != '0);
  assign do_wr      = wr_en && !fifo_full;
  assign do_rd      = rd_en && fifo_valid;
  assign rd_data    = mem_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Record storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (REC_AW+1)'(REC_DEPTH))
    else $error("Record queue count out of range.");
`endif

endmodule

[rtl/tspb_back.sv]
module tspb_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           rec_valid,
  input  tspb_pkg::rec_t rec,
  output logic           rec_pop,
  input  logic           pop,
  output logic           empty,
  output tspb_pkg::res_t res
);
  import tspb_pkg::*;

  logic        out_valid_r;
  res_t        res_r, res_nxt;
  logic [15:0] ent_num;

  assign ent_num = rec.payload[31:16];
  assign rec_pop = rec_valid && (!out_valid_r || pop);
  assign empty   = !out_valid_r;
  assign res     = res_r;

  // Turn a record's raw bytes into result fields.
  always_comb begin
    res_nxt = '0;
    case (rec.tag)
      TAG_HDR: begin
        res_nxt.kind       = KIND_HDR;
        res_nxt.pid        = {rec.payload[20:16], rec.payload[15:8]};
        res_nxt.flags      = rec.payload[23:21];
        res_nxt.scrambling = rec.payload[7:6];
        res_nxt.adaptation = rec.payload[5:4];
        res_nxt.continuity = rec.payload[3:0];
      end
      TAG_SEC: begin
        res_nxt.kind         = KIND_SEC;
        res_nxt.tbl_id       = rec.payload[63:56];
        res_nxt.sec_len      = {rec.payload[51:48], rec.payload[47:40]};
        res_nxt.number       = rec.payload[39:24];
        res_nxt.version      = rec.payload[21:17];
        res_nxt.flags        = {1'b0, rec.payload[55], rec.payload[16]};
        res_nxt.sec_num      = rec.payload[15:8];
        res_nxt.last_section = rec.payload[7:0];
      end
      TAG_ENTRY: begin
        res_nxt.kind   = (ent_num == 16'd0) ? KIND_NET : KIND_PMT;
        res_nxt.pid    = {rec.payload[12:8], rec.payload[7:0]};
        res_nxt.number = ent_num;
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  // Output register: holds one result until it is popped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rec_pop) begin
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      res_r <= res_nxt;
    end
  end

`ifndef SYNTHESIS
  a_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (rec_valid && !out_valid_r) |=> out_valid_r)
    else $error("Waiting record was not moved to the output register.");
`endif

endmodule

[rtl/ts_pat_byte_parser.sv]
// Transport-stream PAT parser. Accepts one byte per clock on in_data_byte
// (push/full) and hunts for the 0x47 sync byte; each packet of PACKET_BYTES
// bytes then yields a packet-header item at byte 3, a PAT section-header item
// at byte 12 and one item per complete program entry, at most MAX_ENTRIES per
// packet. Items leave through empty/pop and one can be taken every clock; an
// item passes through the record queue and then the output register. full rises only
// when the four-record queue between the byte parser and the output
// formatter is full, so the input runs at one byte per clock as long as the
// result side keeps popping. The CRC is not checked and pointer_field is
// assumed to be zero.
module ts_pat_byte_parser #(
  parameter int PACKET_BYTES = 188,
  parameter int MAX_ENTRIES  = 43
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_kind,
  output logic [12:0] out_pid,
  output logic [15:0] out_number,
  output logic [7:0]  out_tbl_id,
  output logic [11:0] out_sec_len,
  output logic [4:0]  out_version,
  output logic [2:0]  out_flags,
  output logic [7:0]  out_sec_num,
  output logic [7:0]  out_last_section,
  output logic [1:0]  out_scrambling,
  output logic [1:0]  out_adaptation,
  output logic [3:0]  out_continuity
);
  import tspb_pkg::*;

  logic acc;
  logic rec_push;
  rec_t rec_in;
  rec_t rec_out;
  logic rec_valid;
  logic rec_pop;
  res_t res;

  assign acc = push && !full;

  // Byte parser: packet tracking and classification.
  tspb_front #(
    .PACKET_BYTES(PACKET_BYTES),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .in_data_byte(in_data_byte),
    .rec_push    (rec_push),
    .rec         (rec_in)
  );

  // Record queue decoupling the parser from the result side.
  tspb_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (rec_push),
    .wr_data   (rec_in),
    .fifo_full (full),
    .rd_en     (rec_pop),
    .rd_data   (rec_out),
    .fifo_valid(rec_valid)
  );

  // Result formatter and output register.
  tspb_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .rec_valid(rec_valid),
    .rec      (rec_out),
    .rec_pop  (rec_pop),
    .pop      (pop),
    .empty    (empty),
    .res      (res)
  );

  assign out_kind         = res.kind;
  assign out_pid          = res.pid;
  assign out_number       = res.number;
  assign out_tbl_id       = res.tbl_id;
  assign out_sec_len      = res.sec_len;
  assign out_version      = res.version;
  assign out_flags        = res.flags;
  assign out_sec_num      = res.sec_num;
  assign out_last_section = res.last_section;
  assign out_scrambling   = res.scrambling;
  assign out_adaptation   = res.adaptation;
  assign out_continuity   = res.continuity;

endmodule

[dv/tb_tspb_score_pkg.sv]
package tspb_score_pkg;

  import tspb_pkg::*;

  // Packet size and entry cap that the testbench builds the block with.
  localparam int PKT_BYTES = 188;
  localparam int ENTRY_CAP = 43;

  // Predicts the items that the parser emits for each accepted byte and
  // checks the items that come out against them in order.
  class pat_parse_scoreboard;

    bit             in_packet;
    int unsigned    byte_idx;
    logic [7:0]     hdr_bytes [HDR_STORE_DEPTH];
    logic [23:0]    entry_hold;
    int unsigned    entries_left;
    res_t           pending_items [$];
    int unsigned    errors;

    function new();
      in_packet    = 1'b0;
      byte_idx     = 0;
      entry_hold   = '0;
      entries_left = 0;
      errors       = 0;
      foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
    endfunction

    function string fmt(res_t r);
      return $sformatf({"kind=%0d pid=%h number=%h tbl_id=%h slen=%h ver=%h ",
                        "flags=%b sec=%h last=%h scr=%b adapt=%b cc=%h"},
                       r.kind, r.pid, r.number, r.tbl_id, r.sec_len,
                       r.version, r.flags, r.sec_num, r.last_section,
                       r.scrambling, r.adaptation, r.continuity);
    endfunction

    // Advance the parse by one accepted byte and queue any item it causes.
    function void note_byte(logic [7:0] b);
      res_t          item;
      int unsigned   idx;
      logic [11:0]   slen;
      int unsigned   n;
      logic [15:0]   num;
      item = '0;
      if (!in_packet) begin
        if (b == SYNC_BYTE) begin
          in_packet = 1'b1;
          byte_idx  = 1;
        end
        return;
      end
      idx = byte_idx;
      if (idx >= 1 && idx <= HDR_STORE_DEPTH) hdr_bytes[idx-1] = b;

      if (idx == HDR_BYTE) begin
        // Packet header: flags and PID from bytes 1 and 2, control bits from byte 3.
        item.kind       = KIND_HDR;
        item.pid        = {hdr_bytes[0][4:0], hdr_bytes[1]};
        item.flags      = {hdr_bytes[0][7], hdr_bytes[0][6], hdr_bytes[0][5]};
        item.scrambling = b[7:6];
        item.adaptation = b[5:4];
        item.continuity = b[3:0];
        pending_items.push_back(item);
      end else if (idx == SEC_BYTE) begin
        // Section header; it also fixes how many entries follow.
        slen = {hdr_bytes[5][3:0], hdr_bytes[6]};
        n = (slen >= SEC_FIXED) ? (int'(slen) - 9) / 4 : 0;
        if (n > ENTRY_CAP) n = ENTRY_CAP;
        entries_left      = n;
        item.kind         = KIND_SEC;
        item.number       = {hdr_bytes[7], hdr_bytes[8]};
        item.tbl_id       = hdr_bytes[4];
        item.sec_len      = slen;
        item.version      = hdr_bytes[9][5:1];
        item.flags        = {1'b0, hdr_bytes[5][7], hdr_bytes[9][0]};
        item.sec_num      = hdr_bytes[10];
        item.last_section = b;
        pending_items.push_back(item);
      end else if (idx >= ENTRY_BASE) begin
        // Program entries: three bytes are held, the fourth completes one.
        if (((idx - ENTRY_BASE) % 4) < 3) begin
          entry_hold = {entry_hold[15:0], b};
        end else if (entries_left > 0) begin
          num         = entry_hold[23:8];
          item.kind   = (num == 16'd0) ? KIND_NET : KIND_PMT;
          item.pid    = {entry_hold[4:0], b};
          item.number = num;
          entries_left--;
          pending_items.push_back(item);
        end
      end

      if (idx + 1 >= PKT_BYTES) begin
        in_packet    = 1'b0;
        byte_idx     = 0;
        entries_left = 0;
      end else begin
        byte_idx = idx + 1;
      end
    endfunction

    // Compare one item taken from the block with the oldest prediction.
    function void check_item(res_t got);
      res_t want;
      if (pending_items.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected item: %s", fmt(got));
        return;
      end
      want = pending_items.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("Item mismatch:");
          $display("  expected %s", fmt(want));
          $display("  actual   %s", fmt(got));
        end
      end
    endfunction

    function int unsigned pending();
      return pending_items.size();
    endfunction

  endclass

endpackage

[dv/tb_ts_pat_byte_parser.sv]
module tb_ts_pat_byte_parser;

  timeunit 1ns;
  timeprecision 1ps;

  import tspb_pkg::*;
  import tspb_score_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int RAND_PACKETS_A = 2;
  localparam int RAND_PACKETS_B = 1;
  localparam int RAND_PACKETS_C = 2;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_data_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  out_kind;
  logic [12:0] out_pid;
  logic [15:0] out_number;
  logic [7:0]  out_tbl_id;
  logic [11:0] out_sec_len;
  logic [4:0]  out_version;
  logic [2:0]  out_flags;
  logic [7:0]  out_sec_num;
  logic [7:0]  out_last_section;
  logic [1:0]  out_scrambling;
  logic [1:0]  out_adaptation;
  logic [3:0]  out_continuity;
  res_t        out_item;

  pat_parse_scoreboard sb;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned stall_cycles = 0;
  logic [7:0]  pkt [PKT_BYTES];

  ts_pat_byte_parser #(
    .PACKET_BYTES(PKT_BYTES),
    .MAX_ENTRIES (ENTRY_CAP)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_data_byte    (in_data_byte),
    .empty           (empty),
    .pop             (pop),
    .out_kind        (out_kind),
    .out_pid         (out_pid),
    .out_number      (out_number),
    .out_tbl_id      (out_tbl_id),
    .out_sec_len     (out_sec_len),
    .out_version     (out_version),
    .out_flags       (out_flags),
    .out_sec_num     (out_sec_num),
    .out_last_section(out_last_section),
    .out_scrambling  (out_scrambling),
    .out_adaptation  (out_adaptation),
    .out_continuity  (out_continuity)
  );

  assign out_item = {out_kind, out_pid, out_number, out_tbl_id, out_sec_len,
                     out_version, out_flags, out_sec_num, out_last_section,
                     out_scrambling, out_adaptation, out_continuity};

  // 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side: take items with random stalls and check each one.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) sb.check_item(out_item);
    pop <= ($urandom_range(99) >= recv_idle);
  end

  // Watchdog: end the run when nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Offer one byte, idling at random first, and hold it until it is taken.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push         <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (full);
    sb.note_byte(b);
  endtask

  task automatic send_packet();
    for (int k = 0; k < PKT_BYTES; k++) send_byte(pkt[k]);
  endtask

  // Noise between packets; a stray sync byte now and then starts a misaligned packet.
  task automatic send_gap();
    int unsigned n;
    logic [7:0]  b;
    n = $urandom_range(4);
    repeat (n) begin
      b = 8'($urandom);
      if (b == SYNC_BYTE && $urandom_range(9) != 0) b = 8'h00;
      send_byte(b);
    end
  endtask

  // Stop sending until every predicted item has been taken.
  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // A well-formed packet with random content. Section lengths lean toward
  // values that give real entry counts, and network entries are common.
  task automatic build_packet();
    logic [11:0] slen;
    case ($urandom_range(3))
      0:       slen = 12'($urandom);
      1:       slen = 12'($urandom_range(12));
      default: slen = 12'(9 + 4 * $urandom_range(46) + $urandom_range(3));
    endcase
    pkt[0] = SYNC_BYTE;
    for (int k = 1; k < PKT_BYTES; k++) pkt[k] = 8'($urandom);
    if ($urandom_range(3) != 0) pkt[4] = 8'h00;
    if ($urandom_range(3) != 0) pkt[5] = 8'h00;
    pkt[6][3:0] = slen[11:8];
    pkt[7]      = slen[7:0];
    for (int k = ENTRY_BASE; k + 3 < PKT_BYTES; k += 4) begin
      if ($urandom_range(3) == 0) begin
        pkt[k]   = 8'h00;
        pkt[k+1] = 8'h00;
      end
    end
    for (int k = 1; k < PKT_BYTES; k++) begin
      if ($urandom_range(39) == 0) pkt[k] = SYNC_BYTE;
    end
  endtask

  task automatic send_random_packets(input int unsigned count);
    repeat (count) begin
      build_packet();
      send_packet();
      send_gap();
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: sender rarely idles, receiver often stalls.
    send_idle = 8;
    recv_idle = 65;

    // Bytes around the sync value while hunting produce nothing.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h46);
    send_byte(8'h48);

    // All ones: widest fields, section length far above the entry cap,
    // one network entry up front and a sync byte in the payload.
    pkt[0] = SYNC_BYTE;
    for (int k = 1; k < PKT_BYTES; k++) pkt[k] = 8'hFF;
    pkt[ENTRY_BASE]     = 8'h00;
    pkt[ENTRY_BASE + 1] = 8'h00;
    pkt[20]             = SYNC_BYTE;
    send_packet();

    // All zeros: zero section length, so no entries.
    pkt[0] = SYNC_BYTE;
    for (int k = 1; k < PKT_BYTES; k++) pkt[k] = 8'h00;
    send_packet();

    // Section length just below the fixed part: no entries.
    build_packet();
    pkt[6][3:0] = 4'h0;
    pkt[7]      = 8'd8;
    send_packet();
    send_gap();

    // One entry past the cap: the count is clipped and the partial tail dropped.
    build_packet();
    pkt[6][3:0] = 4'h0;
    pkt[7]      = 8'd185;
    send_packet();

    send_random_packets(RAND_PACKETS_A);
    drain();

    // Phase two: sender often idles, receiver rarely stalls.
    send_idle = 65;
    recv_idle = 8;
    send_random_packets(RAND_PACKETS_B);
    drain();

    // Phase three: no idling on either side.
    send_idle = 0;
    recv_idle = 0;
    send_random_packets(RAND_PACKETS_C);
    drain();

    // Let any late or extra item show up before the verdict.
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
